>>> hdl/unix_seconds_to_civil_date_assert.svh
// Assertion macros for the Unix seconds to civil date pipeline.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH

// same-cycle implication, held off during reset
`define UCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define UCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ucd_pkg.sv
// Shared types, constants and the month start table for the civil date pipeline.
// No dependencies.
package ucd_pkg;

  localparam int NSTAGE = 12;

  localparam logic signed [38:0] FIRST_SEC = -39'sd62167219200;
  localparam logic signed [38:0] LAST_SEC  = 39'sd253402300799;

  // 86400 = 128 * 675: shift out the power of two, divide the rest by reciprocal
  localparam logic [9:0]  DAY_ODD    = 10'd675;
  localparam logic [30:0] RCP_DAY    = 31'((64'd1 << 40) / 64'd675);
  // offset from days since 0000-01-01 to days since 0000-03-01 plus one era
  localparam logic [21:0] DAY_OFFSET = 22'd146037;

  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [22:0] RCP_ERA    = 23'((64'd1 << 40) / 64'd146097);
  localparam logic [10:0] QUAD_DAYS  = 11'd1460;
  localparam logic [17:0] RCP_QUAD   = 18'((64'd1 << 28) / 64'd1460);
  localparam logic [17:0] CENT_DAYS  = 18'd36524;
  localparam logic [17:0] LAST_DOE   = 18'd146096;
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [19:0] RCP_YEAR   = 20'((64'd1 << 28) / 64'd365);
  localparam logic [8:0]  ERA_YEARS  = 9'd400;

  typedef logic [NSTAGE-1:0] stage_vec_t;

  typedef struct packed {
    stage_vec_t en;
    stage_vec_t vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic        oor;
    logic [21:0] dayp;
  } day_word_t;

  typedef struct packed {
    logic        oor;
    logic [4:0]  era;
    logic [17:0] doe;
    logic [8:0]  yoe;
  } era_word_t;

  typedef struct packed {
    logic        oor;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
  } date_word_t;

  // first day of each month in a year that starts on 1 March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/ucd_pipe_ctrl.sv
// Valid bits and per-stage load enables for the civil date pipeline.
// Depends on ucd_pkg.
module ucd_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output ucd_pkg::pipe_ctl_t ctl
);

  ucd_pkg::stage_vec_t vld_r;
  ucd_pkg::stage_vec_t vld_nxt;
  ucd_pkg::stage_vec_t en;

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    en[ucd_pkg::NSTAGE-1] = !vld_r[ucd_pkg::NSTAGE-1] || out_ready;
    for (int i = ucd_pkg::NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < ucd_pkg::NSTAGE; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_r;

endmodule

>>> hdl/ucd_day_div.sv
// Stages 1 to 3: range check and floor division of seconds into a shifted day count.
// Depends on ucd_pkg.
module ucd_day_div (
  input  logic                   clk,
  input  logic [2:0]             en,
  input  logic signed [38:0]     epoch_seconds,
  output ucd_pkg::day_word_t     day_word
);

  logic              s1_oor_r;
  logic [31:0]       s1_x_r;
  logic              s2_oor_r;
  logic [31:0]       s2_x_r;
  logic [21:0]       s2_q_r;
  ucd_pkg::day_word_t s3_r;

  logic              oor_nxt;
  logic [38:0]       u_nxt;
  logic [62:0]       prod_nxt;
  logic [31:0]       qm_nxt;
  logic [31:0]       rem_nxt;
  logic [21:0]       q_nxt;
  ucd_pkg::day_word_t s3_nxt;

  // seconds from 0000-01-01; valid only when in range
  assign oor_nxt  = (epoch_seconds < ucd_pkg::FIRST_SEC) ||
                    (epoch_seconds > ucd_pkg::LAST_SEC);
  assign u_nxt    = $unsigned(epoch_seconds - ucd_pkg::FIRST_SEC);

  assign prod_nxt = 63'(s1_x_r) * 63'(ucd_pkg::RCP_DAY);

  // estimate is low by at most one: fix with one compare
  assign qm_nxt   = 32'(s2_q_r) * 32'(ucd_pkg::DAY_ODD);
  assign rem_nxt  = s2_x_r - qm_nxt;
  assign q_nxt    = s2_q_r + 22'(rem_nxt >= 32'(ucd_pkg::DAY_ODD));

  always_comb begin
    s3_nxt.oor  = s2_oor_r;
    s3_nxt.dayp = q_nxt + ucd_pkg::DAY_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_oor_r <= oor_nxt;
      s1_x_r   <= u_nxt[38:7];
    end
    if (en[1]) begin
      s2_oor_r <= s1_oor_r;
      s2_x_r   <= s1_x_r;
      s2_q_r   <= prod_nxt[61:40];
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

  assign day_word = s3_r;

endmodule

>>> hdl/ucd_era_split.sv
// Stages 4 to 9: era, day of era and year of era from the shifted day count.
// Depends on ucd_pkg.
module ucd_era_split (
  input  logic               clk,
  input  logic [5:0]         en,
  input  ucd_pkg::day_word_t day_word,
  output ucd_pkg::era_word_t era_word
);

  // stage 4
  logic        s4_oor_r;
  logic [21:0] s4_dayp_r;
  logic [4:0]  s4_e_r;
  // stage 5
  logic        s5_oor_r;
  logic [4:0]  s5_era_r;
  logic [17:0] s5_doe_r;
  // stage 6
  logic        s6_oor_r;
  logic [4:0]  s6_era_r;
  logic [17:0] s6_doe_r;
  logic [6:0]  s6_a_r;
  logic [2:0]  s6_b_r;
  logic        s6_c_r;
  // stage 7
  logic        s7_oor_r;
  logic [4:0]  s7_era_r;
  logic [17:0] s7_doe_r;
  logic [17:0] s7_n_r;
  // stage 8
  logic        s8_oor_r;
  logic [4:0]  s8_era_r;
  logic [17:0] s8_doe_r;
  logic [17:0] s8_n_r;
  logic [8:0]  s8_y_r;
  // stage 9
  ucd_pkg::era_word_t s9_r;

  logic [44:0] p_era_nxt;
  logic [21:0] em_nxt;
  logic [18:0] t_nxt;
  logic        wrap_nxt;
  logic [17:0] doe_nxt;
  logic [35:0] p_quad_nxt;
  logic [2:0]  b_nxt;
  logic [17:0] am_nxt;
  logic [17:0] ar_nxt;
  logic [6:0]  a_nxt;
  logic [18:0] n_nxt;
  logic [37:0] p_year_nxt;
  logic [17:0] ym_nxt;
  logic [17:0] yr_nxt;
  ucd_pkg::era_word_t s9_nxt;

  assign p_era_nxt = 45'(day_word.dayp) * 45'(ucd_pkg::RCP_ERA);

  // remainder below two eras: one subtract corrects the estimate
  assign em_nxt   = 22'(s4_e_r) * 22'(ucd_pkg::ERA_DAYS);
  assign t_nxt    = 19'(s4_dayp_r - em_nxt);
  assign wrap_nxt = t_nxt >= 19'(ucd_pkg::ERA_DAYS);
  assign doe_nxt  = wrap_nxt ? 18'(t_nxt - 19'(ucd_pkg::ERA_DAYS)) : 18'(t_nxt);

  // leap corrections: doe/1460 by reciprocal, doe/36524 and doe/146096 by compares
  assign p_quad_nxt = 36'(s5_doe_r) * 36'(ucd_pkg::RCP_QUAD);
  assign b_nxt = 3'(s5_doe_r >= ucd_pkg::CENT_DAYS) +
                 3'(s5_doe_r >= 18'(2 * ucd_pkg::CENT_DAYS)) +
                 3'(s5_doe_r >= 18'(3 * ucd_pkg::CENT_DAYS)) +
                 3'(s5_doe_r >= ucd_pkg::LAST_DOE);

  assign am_nxt = 18'(s6_a_r) * 18'(ucd_pkg::QUAD_DAYS);
  assign ar_nxt = s6_doe_r - am_nxt;
  assign a_nxt  = s6_a_r + 7'(ar_nxt >= 18'(ucd_pkg::QUAD_DAYS));
  assign n_nxt  = 19'(s6_doe_r) - 19'(a_nxt) + 19'(s6_b_r) - 19'(s6_c_r);

  assign p_year_nxt = 38'(s7_n_r) * 38'(ucd_pkg::RCP_YEAR);

  assign ym_nxt = 18'(s8_y_r) * 18'(ucd_pkg::YEAR_DAYS);
  assign yr_nxt = s8_n_r - ym_nxt;

  always_comb begin
    s9_nxt.oor = s8_oor_r;
    s9_nxt.era = s8_era_r;
    s9_nxt.doe = s8_doe_r;
    s9_nxt.yoe = s8_y_r + 9'(yr_nxt >= 18'(ucd_pkg::YEAR_DAYS));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_oor_r  <= day_word.oor;
      s4_dayp_r <= day_word.dayp;
      s4_e_r    <= p_era_nxt[44:40];
    end
    if (en[1]) begin
      s5_oor_r <= s4_oor_r;
      s5_era_r <= s4_e_r + 5'(wrap_nxt);
      s5_doe_r <= doe_nxt;
    end
    if (en[2]) begin
      s6_oor_r <= s5_oor_r;
      s6_era_r <= s5_era_r;
      s6_doe_r <= s5_doe_r;
      s6_a_r   <= p_quad_nxt[34:28];
      s6_b_r   <= b_nxt;
      s6_c_r   <= (s5_doe_r == ucd_pkg::LAST_DOE);
    end
    if (en[3]) begin
      s7_oor_r <= s6_oor_r;
      s7_era_r <= s6_era_r;
      s7_doe_r <= s6_doe_r;
      s7_n_r   <= n_nxt[17:0];
    end
    if (en[4]) begin
      s8_oor_r <= s7_oor_r;
      s8_era_r <= s7_era_r;
      s8_doe_r <= s7_doe_r;
      s8_n_r   <= s7_n_r;
      s8_y_r   <= p_year_nxt[36:28];
    end
    if (en[5]) begin
      s9_r <= s9_nxt;
    end
  end

  assign era_word = s9_r;

endmodule

>>> hdl/ucd_month_calc.sv
// Stages 10 to 12: day of year, month, day of month and civil year.
// Depends on ucd_pkg.
module ucd_month_calc (
  input  logic                clk,
  input  logic [2:0]          en,
  input  ucd_pkg::era_word_t  era_word,
  output ucd_pkg::date_word_t date_word
);

  logic        s10_oor_r;
  logic [4:0]  s10_era_r;
  logic [8:0]  s10_yoe_r;
  logic [8:0]  s10_doy_r;
  logic        s11_oor_r;
  logic [4:0]  s11_era_r;
  logic [8:0]  s11_yoe_r;
  logic [8:0]  s11_doy_r;
  logic [3:0]  s11_mp_r;
  ucd_pkg::date_word_t s12_r;

  logic [1:0]  cent_nxt;
  logic [17:0] base_nxt;
  logic [17:0] doy_nxt;
  logic [3:0]  mp_nxt;
  logic [3:0]  m_nxt;
  logic [4:0]  d_nxt;
  logic [14:0] ysum_nxt;
  ucd_pkg::date_word_t s12_nxt;

  assign cent_nxt = 2'(era_word.yoe >= 9'd100) + 2'(era_word.yoe >= 9'd200) +
                    2'(era_word.yoe >= 9'd300);
  assign base_nxt = 18'(era_word.yoe) * 18'(ucd_pkg::YEAR_DAYS) +
                    18'(era_word.yoe >> 2) - 18'(cent_nxt);
  assign doy_nxt  = era_word.doe - base_nxt;

  // month index from March: count the month starts already passed
  always_comb begin
    mp_nxt = '0;
    for (int i = 1; i < 12; i++) begin
      mp_nxt = mp_nxt + 4'(s10_doy_r >= ucd_pkg::month_start(4'(i)));
    end
  end

  assign m_nxt = (s11_mp_r < 4'd10) ? s11_mp_r + 4'd3 : s11_mp_r - 4'd9;
  assign d_nxt = 5'(s11_doy_r - ucd_pkg::month_start(s11_mp_r) + 9'd1);

  // era carries a bias of one; January and February roll into the next year
  assign ysum_nxt = 15'(s11_yoe_r) + 15'(s11_era_r) * 15'(ucd_pkg::ERA_YEARS) +
                    15'(m_nxt <= 4'd2) - 15'(ucd_pkg::ERA_YEARS);

  always_comb begin
    s12_nxt.oor = s11_oor_r;
    if (s11_oor_r) begin
      s12_nxt.year  = '0;
      s12_nxt.month = '0;
      s12_nxt.dom   = '0;
    end else begin
      s12_nxt.year  = ysum_nxt[13:0];
      s12_nxt.month = m_nxt;
      s12_nxt.dom   = d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s10_oor_r <= era_word.oor;
      s10_era_r <= era_word.era;
      s10_yoe_r <= era_word.yoe;
      s10_doy_r <= doy_nxt[8:0];
    end
    if (en[1]) begin
      s11_oor_r <= s10_oor_r;
      s11_era_r <= s10_era_r;
      s11_yoe_r <= s10_yoe_r;
      s11_doy_r <= s10_doy_r;
      s11_mp_r  <= mp_nxt;
    end
    if (en[2]) begin
      s12_r <= s12_nxt;
    end
  end

  assign date_word = s12_r;

endmodule

>>> hdl/unix_seconds_to_civil_date.sv
// Top level: Unix seconds to proleptic Gregorian year, month and day.
// Depends on ucd_pkg, ucd_pipe_ctrl, ucd_day_div, ucd_era_split, ucd_month_calc
// and unix_seconds_to_civil_date_assert.svh.
//
//   channel | ports                                   | dir | word
//   --------+-----------------------------------------+-----+-------------------------
//   in      | in_valid, in_ready, in_epoch_seconds    | in  | signed 39-bit seconds
//   out     | out_valid, out_ready, out_year, ...     | out | year, month, day, range
//
// Twelve register stages; one word enters per cycle while the output side keeps up,
// and results leave in the order their words were taken.
// Latency is set by the four reciprocal multiply-and-correct divisions.
// Reset clears the valid bits only; data registers hold whatever they had.
// A stall holds each full stage whose successor cannot load; empty stages
// still fill, so bubbles close up behind a stalled output.
module unix_seconds_to_civil_date (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [38:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic               out_out_of_range
);

  ucd_pkg::pipe_ctl_t  ctl;
  ucd_pkg::day_word_t  day_word;
  ucd_pkg::era_word_t  era_word;
  ucd_pkg::date_word_t date_word;

  logic fields_zero;
  logic fields_sane;

  ucd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  ucd_day_div u_day_div (
    .clk           (clk),
    .en            (ctl.en[2:0]),
    .epoch_seconds (in_epoch_seconds),
    .day_word      (day_word)
  );

  ucd_era_split u_era_split (
    .clk      (clk),
    .en       (ctl.en[8:3]),
    .day_word (day_word),
    .era_word (era_word)
  );

  ucd_month_calc u_month_calc (
    .clk       (clk),
    .en        (ctl.en[11:9]),
    .era_word  (era_word),
    .date_word (date_word)
  );

  assign in_ready         = ctl.en[0];
  assign out_valid        = ctl.vld[ucd_pkg::NSTAGE-1];
  assign out_year         = date_word.year;
  assign out_month        = date_word.month;
  assign out_day_of_month = date_word.dom;
  assign out_out_of_range = date_word.oor;

  assign fields_zero = (out_year == 14'd0) && (out_month == 4'd0) &&
                       (out_day_of_month == 5'd0);
  assign fields_sane = (out_month >= 4'd1) && (out_month <= 4'd12) &&
                       (out_day_of_month != 5'd0) && (out_year <= 14'd9999);

`include "unix_seconds_to_civil_date_assert.svh"

  `UCD_ASSERT_NXT(a_take_lands, in_valid && in_ready, ctl.vld[0], "accepted word lost")
  `UCD_ASSERT_IMP(a_oor_zero, out_valid && out_out_of_range, fields_zero, "oor not zeroed")
  `UCD_ASSERT_IMP(a_date_sane, out_valid && !out_out_of_range, fields_sane, "date out of bounds")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for unix_seconds_to_civil_date: drives signed second counts,
// predicts each date in-bench and checks it. Depends on ucd_pkg and the block's RTL.
module tb_top;

  localparam longint SECS_PER_DAY = 86400;
  localparam longint MARCH_SHIFT  = 719468;
  localparam longint ERA_LEN      = 146097;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = ucd_pkg::NSTAGE + 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [38:0] in_epoch_seconds;
  logic               out_valid;
  logic               out_ready;
  logic [13:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day_of_month;
  logic               out_out_of_range;

  ucd_pkg::date_word_t expected_dates[$];
  logic       no_idle;
  int         words_taken;
  int         dates_seen;
  int         oor_seen;
  int         faults;
  int         quiet_cycles;

  unix_seconds_to_civil_date u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor to a day, then split into 400-year eras counted from 0000-03-01
  function automatic ucd_pkg::date_word_t civil_date_of(input logic signed [38:0] secs);
    longint s, day_no, era, doe, yoe, doy, mp, yr, mon;
    ucd_pkg::date_word_t d;
    s = secs;
    d = '0;
    if (s < ucd_pkg::FIRST_SEC || s > ucd_pkg::LAST_SEC) begin
      d.oor = 1'b1;
      return d;
    end
    day_no = s / SECS_PER_DAY;
    if (s < 0 && (s % SECS_PER_DAY) != 0) day_no -= 1;
    day_no += MARCH_SHIFT;
    era = (day_no >= 0 ? day_no : day_no - (ERA_LEN - 1)) / ERA_LEN;
    doe = day_no - era * ERA_LEN;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr  = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    // January and February close the March-based year
    if (mon <= 2) yr += 1;
    d.year  = 14'(yr);
    d.month = 4'(mon);
    d.dom   = 5'(doy - (153 * mp + 2) / 5 + 1);
    return d;
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // hold valid and the word until taken; idle at random beforehand
  task automatic send_word(input logic signed [38:0] secs);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= no_idle || ($urandom_range(0, 99) >= 28);
    end
  end

  always @(posedge clk) begin : result_check
    ucd_pkg::date_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(civil_date_of(in_epoch_seconds));
        words_taken++;
      end
      if (out_valid && out_ready) begin
        dates_seen++;
        if (out_out_of_range) oor_seen++;
        if (expected_dates.size() == 0) begin
          note_fault($sformatf("unexpected word: y=%0d m=%0d d=%0d oor=%0b",
                               out_year, out_month, out_day_of_month, out_out_of_range));
        end else begin
          want = expected_dates.pop_front();
          if (out_year !== want.year || out_month !== want.month ||
              out_day_of_month !== want.dom || out_out_of_range !== want.oor) begin
            note_fault($sformatf(
              "mismatch: want y=%0d m=%0d d=%0d oor=%0b, got y=%0d m=%0d d=%0d oor=%0b",
              want.year, want.month, want.dom, want.oor,
              out_year, out_month, out_day_of_month, out_out_of_range));
          end
        end
      end
    end
  end

  // give up after a long stretch with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout with %0d dates outstanding", expected_dates.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_directed;
    logic signed [38:0] edges[$];
    edges = '{ucd_pkg::FIRST_SEC, ucd_pkg::FIRST_SEC - 39'sd1,
              ucd_pkg::LAST_SEC, ucd_pkg::LAST_SEC + 39'sd1,
              39'sd0, -39'sd1, -39'sd86399, -39'sd86400, -39'sd86401,
              39'sh3F_FFFF_FFFF, 39'sh40_0000_0000,
              ucd_pkg::FIRST_SEC + 39'sd5097600, ucd_pkg::FIRST_SEC + 39'sd5183999,
              ucd_pkg::FIRST_SEC + 39'sd5184000, ucd_pkg::LAST_SEC - 39'sd86399,
              39'sd951782400, 39'sd951868799, 39'sd951868800,
              -39'sd2203891200, -39'sd2203891201, 39'sd2147483648};
    foreach (edges[i]) send_word(edges[i]);
  endtask

  // seconds either side of midnight or at midday on random days, a little past each end too
  task automatic test_day_edges(input int count);
    longint day_start;
    longint nudge;
    repeat (count) begin
      day_start = longint'(ucd_pkg::FIRST_SEC) +
                  longint'($urandom_range(0, 3652425)) * SECS_PER_DAY;
      case ($urandom_range(0, 4))
        0:       nudge = -1;
        1:       nudge = 0;
        2:       nudge = 1;
        3:       nudge = SECS_PER_DAY / 2;
        default: nudge = SECS_PER_DAY - 1;
      endcase
      send_word(39'(day_start + nudge));
    end
  endtask

  task automatic test_random_span(input int count, input int steady_count);
    longint unsigned span;
    longint unsigned pick;
    int n;
    span = longint'(ucd_pkg::LAST_SEC) - longint'(ucd_pkg::FIRST_SEC) + 2001;
    n = 0;
    repeat (count) begin
      no_idle = (n < steady_count);
      pick = {$urandom, $urandom};
      send_word(39'(longint'(ucd_pkg::FIRST_SEC) - 1000 + longint'(pick % span)));
      n++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_raw(input int count);
    logic [63:0] raw;
    repeat (count) begin
      raw = {$urandom, $urandom};
      send_word(raw[38:0]);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    no_idle          = 1'b0;
    words_taken      = 0;
    dates_seen       = 0;
    oor_seen         = 0;
    faults           = 0;
    quiet_cycles     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_day_edges(100);
    test_random_span(200, 60);
    test_random_raw(130);
    in_valid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d second counts, checked %0d dates (%0d out of range)",
             words_taken, dates_seen, oor_seen);
    $display("%0d faults logged", faults);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
